>>> rtl/bounded_sequence_list_unit_assert.svh
// Assertion macros shared by the RTL of the sequence list unit.
// Each macro expands to a concurrent assertion in simulation and to nothing
// when the code is synthesized.
`ifndef BOUNDED_SEQUENCE_LIST_UNIT_ASSERT_SVH
`define BOUNDED_SEQUENCE_LIST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define BSL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bounded_sequence_list_unit: assertion failed");

`define BSL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bounded_sequence_list_unit: implication failed");

`else

`define BSL_ASSERT(lbl, clk, rstn, prop)

`define BSL_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/bsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsl_pkg;

  localparam int ActionW = 3;
  localparam int PosW    = 5;
  localparam int DataW   = 32;
  localparam int LenW    = 5;
  localparam int StatW   = 2;

  localparam logic [ActionW-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ActionW-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ActionW-1:0] ACT_INSERT     = 3'd2;
  localparam logic [ActionW-1:0] ACT_ERASE      = 3'd3;
  localparam logic [ActionW-1:0] ACT_POP_FRONT  = 3'd4;
  localparam logic [ActionW-1:0] ACT_POP_BACK   = 3'd5;
  localparam logic [ActionW-1:0] ACT_READ       = 3'd6;

  localparam logic [StatW-1:0] STAT_DONE  = 2'd0;
  localparam logic [StatW-1:0] STAT_RANGE = 2'd1;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd2;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd3;

  typedef struct packed {
    logic [ActionW-1:0]      action;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } bsl_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [LenW-1:0]         length;
    logic [StatW-1:0]        status;
  } bsl_out_t;

endpackage

`default_nettype wire

>>> rtl/bounded_sequence_list_unit.sv
// Ordered list of up to CAPACITY signed 32-bit values with deque and indexed
// access. One request enters on the in_ channel (valid/ready); exactly one
// response leaves on the out_ channel carrying the new length, a status and,
// for a read, the stored value.
// Requests are handled one at a time; in_ready is high only while the unit
// is idle. Elements live in a single-port-write, one-read synchronous RAM,
// so an insert or erase moves one element per cycle through the RAM's read
// latency. An insert or a front push with later elements shifts them up
// (S_UP), then writes the value (S_PUT); an erase or a front pop with later
// elements shifts them down (S_DOWN); a back push or an insert at the end
// only writes (S_PUT). Each then loads the response register (S_RESP); a back
// pop, a read, an unused action or a refused request goes straight there. The
// next request is taken in the cycle after the response register loads.
// The response sits in an output register. While it waits for out_ready the
// unit still accepts and works on the next request; it stalls only when a
// second response is ready before the first one has been taken.
// rst_n is synchronous and active low. It empties the list and drops any
// pending response; the RAM itself is not cleared, since no entry at or
// above the length is ever read.
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_sequence_list_unit_assert.svh"

module bounded_sequence_list_unit
  import bsl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_ready,
  input  bsl_in_t  in_data,
  output logic     out_valid,
  input  wire      out_ready,
  output bsl_out_t out_data
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > PosW) ? CW : PosW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_DOWN = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic signed [DataW-1:0] cells [CAPACITY];

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic [AW-1:0]           stop_r, stop_nxt;
  logic [AW-1:0]           put_r, put_nxt;
  logic signed [DataW-1:0] val_r, val_nxt;
  logic                    is_rd_r, is_rd_nxt;
  logic [StatW-1:0]        status_r, status_nxt;
  logic                    wb_valid_r, wb_valid_nxt;
  logic [AW-1:0]           wb_addr_r, wb_addr_nxt;
  logic signed [DataW-1:0] rdata_r;
  logic                    out_valid_r, out_valid_nxt;
  bsl_out_t                out_data_r, out_data_nxt;

  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [DataW-1:0] mem_wdata;

  logic [CMPW-1:0]         pos_ext;
  logic [CMPW-1:0]         cnt_ext;
  logic [AW-1:0]           pos_a;
  logic [AW-1:0]           cnt_a;
  logic [AW-1:0]           cnt_m1;
  logic                    full;
  logic                    empty;

  assign pos_ext = CMPW'(in_data.position);
  assign cnt_ext = CMPW'(count_r);
  assign pos_a   = AW'(in_data.position);
  assign cnt_a   = AW'(count_r);
  assign cnt_m1  = AW'(count_r - 1'b1);
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    stop_nxt      = stop_r;
    put_nxt       = put_r;
    val_nxt       = val_r;
    is_rd_nxt     = is_rd_r;
    status_nxt    = status_r;
    wb_valid_nxt  = 1'b0;
    wb_addr_nxt   = wb_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r;
    mem_we        = wb_valid_r;
    mem_waddr     = wb_addr_r;
    mem_wdata     = rdata_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt    = in_data.value;
          is_rd_nxt  = 1'b0;
          status_nxt = STAT_DONE;
          state_nxt  = S_RESP;
          case (in_data.action)
            ACT_PUSH_FRONT: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
                put_nxt   = '0;
                if (empty) begin
                  state_nxt = S_PUT;
                end else begin
                  ptr_nxt   = cnt_m1;
                  stop_nxt  = '0;
                  state_nxt = S_UP;
                end
              end
            end
            ACT_PUSH_BACK: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
                put_nxt   = cnt_a;
                state_nxt = S_PUT;
              end
            end
            ACT_INSERT: begin
              if (pos_ext > cnt_ext) begin
                status_nxt = STAT_RANGE;
              end else if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                count_nxt = count_r + 1'b1;
                put_nxt   = pos_a;
                if (pos_ext == cnt_ext) begin
                  state_nxt = S_PUT;
                end else begin
                  ptr_nxt   = cnt_m1;
                  stop_nxt  = pos_a;
                  state_nxt = S_UP;
                end
              end
            end
            ACT_ERASE: begin
              if (pos_ext >= cnt_ext) begin
                status_nxt = STAT_RANGE;
              end else begin
                count_nxt = count_r - 1'b1;
                if (pos_a != cnt_m1) begin
                  ptr_nxt   = pos_a + 1'b1;
                  stop_nxt  = cnt_m1;
                  state_nxt = S_DOWN;
                end
              end
            end
            ACT_POP_FRONT: begin
              if (empty) begin
                status_nxt = STAT_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
                if (cnt_m1 != '0) begin
                  ptr_nxt   = AW'(1);
                  stop_nxt  = cnt_m1;
                  state_nxt = S_DOWN;
                end
              end
            end
            ACT_POP_BACK: begin
              if (empty) begin
                status_nxt = STAT_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            ACT_READ: begin
              if (pos_ext >= cnt_ext) begin
                status_nxt = STAT_RANGE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = pos_a;
                is_rd_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // Walk from the back toward the insert point; each element read here
      // is written one place further back in the following cycle.
      S_UP: begin
        rd_en        = 1'b1;
        rd_addr      = ptr_r;
        wb_valid_nxt = 1'b1;
        wb_addr_nxt  = ptr_r + 1'b1;
        if (ptr_r == stop_r) begin
          state_nxt = S_PUT;
        end else begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      S_DOWN: begin
        rd_en        = 1'b1;
        rd_addr      = ptr_r;
        wb_valid_nxt = 1'b1;
        wb_addr_nxt  = ptr_r - 1'b1;
        if (ptr_r == stop_r) begin
          state_nxt = S_RESP;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      // The new value takes the write port once the last moved element is in.
      S_PUT: begin
        if (!wb_valid_r) begin
          mem_we    = 1'b1;
          mem_waddr = put_r;
          mem_wdata = val_r;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!wb_valid_r && (!out_valid_r || out_ready)) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_value = is_rd_r ? rdata_r : '0;
          out_data_nxt.length     = LenW'(count_r);
          out_data_nxt.status     = status_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= cells[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wb_valid_r  <= wb_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    stop_r     <= stop_nxt;
    put_r      <= put_nxt;
    val_r      <= val_nxt;
    is_rd_r    <= is_rd_nxt;
    status_r   <= status_nxt;
    wb_addr_r  <= wb_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  `BSL_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY))
  `BSL_ASSERT_IMP(a_idle_no_wb, clk, rst_n, state_r == S_IDLE, !wb_valid_r)
  `BSL_ASSERT(a_accept_leaves_idle, clk, rst_n, (in_valid && in_ready) |=> (state_r != S_IDLE))
  `BSL_ASSERT_IMP(a_resp_from_resp, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_RESP)

endmodule

`default_nettype wire
